### rtl/srcv_pkg.sv
// ----------------------------------------------------------------------------
// Stick rate curve package
// Shared types, register codes, fixed-point constants and helper functions.
// ----------------------------------------------------------------------------
package srcv_pkg;

    // Working width for rounding shifts; every product fits well inside it.
    localparam int RW          = 80;
    localparam int DIV_STEPS   = 23;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int CFG_AW      = 3;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] REG_RATE_MODE  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_RATE_A     = 3'd1;
    localparam logic [CFG_AW-1:0] REG_RATE_B     = 3'd2;
    localparam logic [CFG_AW-1:0] REG_ACRO_EXPO  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_ANGLE_EXPO = 3'd4;

    // Curve select codes.
    localparam logic [1:0] MODE_CUBIC   = 2'd0;
    localparam logic [1:0] MODE_RC      = 2'd1;
    localparam logic [1:0] MODE_QUINTIC = 2'd2;

    // Axis codes.
    localparam logic [1:0] AXIS_ROLL  = 2'd0;
    localparam logic [1:0] AXIS_PITCH = 2'd1;
    localparam logic [1:0] AXIS_YAW   = 2'd2;

    localparam logic signed [17:0] ONE_Q12     = 18'sd4096;
    localparam logic [15:0]        TWO_Q12     = 16'd8192;
    localparam logic [15:0]        BOOST_Q12   = 16'd59556;
    localparam logic [27:0]        D_ONE_Q27   = 28'd134217728;
    localparam logic [27:0]        D_MIN_Q27   = 28'd1342177;
    localparam logic [22:0]        DEG2RAD_Q28 = 23'd4685083;
    localparam logic [7:0]         RATE_SCALE  = 8'd200;
    localparam logic signed [47:0] DEG_LIMIT   = 48'sh0100_0000_0000;
    localparam logic signed [35:0] RAD_MAX     = 36'sd2147483647;
    localparam logic signed [35:0] RAD_MIN     = -36'sd2147483648;

    // One classified item waiting for the curve pipeline.
    typedef struct packed {
        logic [1:0]         axis;
        logic [1:0]         mode;
        logic signed [15:0] stick;
        logic [15:0]        expo;
        logic [15:0]        rate_a;
        logic [15:0]        rate_b;
    } t_job;

    // Per-item data that rides along the quotient pipeline.
    typedef struct packed {
        logic [1:0]         axis;
        logic [1:0]         mode;
        logic signed [40:0] deg0;
        logic signed [40:0] deg2;
        logic signed [40:0] ang;
    } t_div_pay;

    typedef struct packed {
        t_div_pay    pay;
        logic [27:0] den;
    } t_curve_res;

    // Shift right by n, rounding to nearest with ties away from zero.
    function automatic logic signed [RW-1:0] rnd_shr(input logic signed [RW-1:0] v,
                                                     input int n);
        logic signed [RW-1:0] half;
        logic signed [RW-1:0] neg;
        half      = '0;
        half[n-1] = 1'b1;
        neg       = '0;
        neg[0]    = v[RW-1];
        return (v + half - neg) >>> n;
    endfunction

    // Picks one axis word out of a packed register; the fourth axis reads zero.
    function automatic logic [15:0] word_sel(input logic [47:0] pack, input logic [1:0] axis);
        logic [15:0] w;
        unique case (axis)
            AXIS_ROLL:  w = pack[15:0];
            AXIS_PITCH: w = pack[31:16];
            AXIS_YAW:   w = pack[47:32];
            default:    w = '0;
        endcase
        return w;
    endfunction

endpackage

### rtl/srcv_if.sv
// ----------------------------------------------------------------------------
// Stick rate curve channels
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface srcv_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         axis_index;
    logic signed [15:0] stick;
    logic               level_on;
    logic               race_on;
    logic               horizon_on;

    modport source (output valid, axis_index, stick, level_on, race_on, horizon_on,
                    input ready);
    modport sink (input valid, axis_index, stick, level_on, race_on, horizon_on,
                  output ready);
endinterface

interface srcv_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         axis_out;
    logic signed [31:0] rate_rad;
    logic               saturated;

    modport source (output valid, axis_out, rate_rad, saturated, input ready);
    modport sink (input valid, axis_out, rate_rad, saturated, output ready);
endinterface

interface srcv_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [47:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/srcv_front.sv
// ----------------------------------------------------------------------------
// Stick rate curve front end
// Holds the configuration registers, accepts items and picks their words.
// ----------------------------------------------------------------------------
module srcv_front import srcv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srcv_in_if.sink     i_in,
    srcv_cfg_if.sink    i_cfg,
    input  logic        i_full,
    output logic        o_push,
    output t_job        o_job
);

    logic [1:0]  r_rate_mode;
    logic [47:0] r_rate_a;
    logic [47:0] r_rate_b;
    logic [47:0] r_acro_expo;
    logic [47:0] r_angle_expo;
    logic        w_use_angle;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_mode  <= '0;
            r_rate_a     <= '0;
            r_rate_b     <= '0;
            r_acro_expo  <= '0;
            r_angle_expo <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_RATE_MODE:  r_rate_mode  <= i_cfg.data[1:0];
                REG_RATE_A:     r_rate_a     <= i_cfg.data;
                REG_RATE_B:     r_rate_b     <= i_cfg.data;
                REG_ACRO_EXPO:  r_acro_expo  <= i_cfg.data;
                REG_ANGLE_EXPO: r_angle_expo <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Race mode keeps pitch on acro expo; horizon keeps roll and pitch on acro.
    always_comb begin
        if (!i_in.level_on) begin
            w_use_angle = 1'b0;
        end else if (i_in.race_on && !i_in.horizon_on) begin
            w_use_angle = (i_in.axis_index != AXIS_PITCH);
        end else if (i_in.horizon_on) begin
            w_use_angle = (i_in.axis_index == AXIS_YAW);
        end else begin
            w_use_angle = 1'b1;
        end
    end

    assign i_in.ready   = !i_full;
    assign o_push       = i_in.valid && !i_full;
    assign o_job.axis   = i_in.axis_index;
    assign o_job.mode   = r_rate_mode;
    assign o_job.stick  = i_in.stick;
    assign o_job.expo   = word_sel(w_use_angle ? r_angle_expo : r_acro_expo, i_in.axis_index);
    assign o_job.rate_a = word_sel(r_rate_a, i_in.axis_index);
    assign o_job.rate_b = word_sel(r_rate_b, i_in.axis_index);

endmodule

### rtl/srcv_queue.sv
// ----------------------------------------------------------------------------
// Stick rate curve item queue
// Short FIFO that decouples the front end from the curve pipeline.
// ----------------------------------------------------------------------------
module srcv_queue import srcv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

endmodule

### rtl/srcv_curve.sv
// ----------------------------------------------------------------------------
// Stick rate curve polynomial pipeline
// Seven stages that build the three curves and the super-rate divisor.
// ----------------------------------------------------------------------------
module srcv_curve import srcv_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  t_job       i_job,
    output logic       o_valid,
    output t_curve_res o_res
);

    logic [6:0] r_v;

    // Stage 1 registers.
    logic signed [36:0] r_s1_lin;
    logic signed [31:0] r_s1_x2;
    logic [15:0]        r_s1_abs;
    logic [31:0]        r_s1_boost;
    logic [31:0]        r_s1_sb;
    logic [15:0]        r_s1_move;
    logic signed [15:0] r_s1_s;
    logic [15:0]        r_s1_e;
    logic [15:0]        r_s1_a;
    logic [1:0]         r_s1_axis;
    logic [1:0]         r_s1_mode;
    // Stage 2 registers.
    logic signed [31:0] r_s2_x3;
    logic signed [31:0] r_s2_x4;
    logic [20:0]        r_s2_r;
    logic [27:0]        r_s2_d;
    logic signed [36:0] r_s2_lin;
    logic signed [31:0] r_s2_x2;
    logic [15:0]        r_s2_abs;
    logic [15:0]        r_s2_move;
    logic signed [15:0] r_s2_s;
    logic [15:0]        r_s2_e;
    logic [15:0]        r_s2_a;
    logic [1:0]         r_s2_axis;
    logic [1:0]         r_s2_mode;
    // Stage 3 registers.
    logic signed [31:0] r_s3_xq;
    logic signed [31:0] r_s3_x5;
    logic signed [35:0] r_s3_t0;
    logic signed [36:0] r_s3_lin;
    logic [15:0]        r_s3_a;
    logic [20:0]        r_s3_r;
    logic [27:0]        r_s3_d;
    logic [15:0]        r_s3_abs;
    logic [15:0]        r_s3_move;
    logic signed [15:0] r_s3_s;
    logic [15:0]        r_s3_e;
    logic [1:0]         r_s3_axis;
    logic [1:0]         r_s3_mode;
    // Stage 4 registers.
    logic signed [35:0] r_s4_t1;
    logic signed [35:0] r_s4_t2;
    logic signed [37:0] r_s4_c0;
    logic signed [36:0] r_s4_lin;
    logic [15:0]        r_s4_a;
    logic [20:0]        r_s4_r;
    logic [27:0]        r_s4_d;
    logic [15:0]        r_s4_abs;
    logic [15:0]        r_s4_move;
    logic signed [15:0] r_s4_s;
    logic [1:0]         r_s4_axis;
    logic [1:0]         r_s4_mode;
    // Stage 5 registers.
    logic signed [37:0] r_s5_c1;
    logic signed [37:0] r_s5_inner;
    logic signed [40:0] r_s5_deg0;
    logic [20:0]        r_s5_r;
    logic [27:0]        r_s5_d;
    logic [15:0]        r_s5_abs;
    logic [15:0]        r_s5_move;
    logic signed [15:0] r_s5_s;
    logic [15:0]        r_s5_a;
    logic [1:0]         r_s5_axis;
    logic [1:0]         r_s5_mode;
    // Stage 6 registers.
    logic signed [32:0] r_s6_angp;
    logic signed [37:0] r_s6_rexpo;
    logic signed [32:0] r_s6_sa;
    logic signed [40:0] r_s6_deg0;
    logic [27:0]        r_s6_d;
    logic [15:0]        r_s6_move;
    logic [1:0]         r_s6_axis;
    logic [1:0]         r_s6_mode;
    // Stage 7 register.
    t_curve_res         r_res;

    logic signed [17:0]    w_ome;
    logic signed [33:0]    w_plin;
    logic signed [31:0]    w_x2;
    logic signed [16:0]    w_s17;
    logic signed [16:0]    w_abs17;
    logic [31:0]           w_boost;
    logic [31:0]           w_sb;
    logic signed [47:0]    w_px3;
    logic signed [63:0]    w_px4;
    logic signed [RW-1:0]  w_bq;
    logic [27:0]           w_d;
    logic signed [47:0]    w_pxq;
    logic signed [63:0]    w_px5;
    logic signed [48:0]    w_pt0;
    logic signed [48:0]    w_pt1;
    logic signed [48:0]    w_pt2;
    logic signed [54:0]    w_pd0;
    logic signed [59:0]    w_pang;
    logic signed [54:0]    w_prx;
    logic signed [32:0]    w_sa;
    logic signed [54:0]    w_pmv;
    logic signed [RW-1:0]  w_c2;
    logic signed [41:0]    w_ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    // Stage 1: linear term, square, boost product and super-rate product.
    always_comb begin
        w_ome   = ONE_Q12 - $signed({2'b00, i_job.expo});
        w_plin  = i_job.stick * w_ome;
        w_x2    = i_job.stick * i_job.stick;
        w_s17   = 17'(i_job.stick);
        w_abs17 = w_s17[16] ? -w_s17 : w_s17;
        w_boost = (i_job.rate_a > TWO_Q12) ?
                  32'(i_job.rate_a - TWO_Q12) * 32'(BOOST_Q12) : '0;
        w_sb    = 32'(w_abs17[15:0]) * 32'(i_job.rate_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_lin   <= 37'(w_plin) <<< 3;
            r_s1_x2    <= w_x2;
            r_s1_abs   <= w_abs17[15:0];
            r_s1_boost <= w_boost;
            r_s1_sb    <= w_sb;
            r_s1_move  <= (i_job.rate_b > i_job.rate_a) ? i_job.rate_b - i_job.rate_a : '0;
            r_s1_s     <= i_job.stick;
            r_s1_e     <= i_job.expo;
            r_s1_a     <= i_job.rate_a;
            r_s1_axis  <= i_job.axis;
            r_s1_mode  <= i_job.mode;
        end
    end

    // Stage 2: cube, fourth power, boosted rc rate and clamped divisor.
    always_comb begin
        w_px3 = r_s1_x2 * r_s1_s;
        w_px4 = r_s1_x2 * r_s1_x2;
        w_bq  = rnd_shr(RW'($signed({1'b0, r_s1_boost})), 12);
        w_d   = (r_s1_sb >= 32'(D_ONE_Q27 - D_MIN_Q27)) ? D_MIN_Q27 :
                28'(32'(D_ONE_Q27) - r_s1_sb);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_x3   <= 32'(rnd_shr(RW'(w_px3), 15));
            r_s2_x4   <= 32'(rnd_shr(RW'(w_px4), 30));
            r_s2_r    <= 21'(r_s1_a) + 21'(w_bq);
            r_s2_d    <= w_d;
            r_s2_lin  <= r_s1_lin;
            r_s2_x2   <= r_s1_x2;
            r_s2_abs  <= r_s1_abs;
            r_s2_move <= r_s1_move;
            r_s2_s    <= r_s1_s;
            r_s2_e    <= r_s1_e;
            r_s2_a    <= r_s1_a;
            r_s2_axis <= r_s1_axis;
            r_s2_mode <= r_s1_mode;
        end
    end

    // Stage 3: x^4 times x, fifth power and the cubic expo term.
    always_comb begin
        w_pxq = r_s2_x4 * r_s2_s;
        w_px5 = r_s2_x3 * r_s2_x2;
        w_pt0 = r_s2_x3 * $signed({1'b0, r_s2_e});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_xq   <= 32'(rnd_shr(RW'(w_pxq), 15));
            r_s3_x5   <= 32'(rnd_shr(RW'(w_px5), 30));
            r_s3_t0   <= 36'(rnd_shr(RW'(w_pt0), 12));
            r_s3_lin  <= r_s2_lin;
            r_s3_a    <= r_s2_a;
            r_s3_r    <= r_s2_r;
            r_s3_d    <= r_s2_d;
            r_s3_abs  <= r_s2_abs;
            r_s3_move <= r_s2_move;
            r_s3_s    <= r_s2_s;
            r_s3_e    <= r_s2_e;
            r_s3_axis <= r_s2_axis;
            r_s3_mode <= r_s2_mode;
        end
    end

    // Stage 4: expo terms of the rc and quintic curves, cubic curve sum.
    always_comb begin
        w_pt1 = r_s3_xq * $signed({1'b0, r_s3_e});
        w_pt2 = r_s3_x5 * $signed({1'b0, r_s3_e});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s4_t1   <= 36'(rnd_shr(RW'(w_pt1), 12));
            r_s4_t2   <= 36'(rnd_shr(RW'(w_pt2), 12));
            r_s4_c0   <= 38'(r_s3_t0) + 38'(r_s3_lin);
            r_s4_lin  <= r_s3_lin;
            r_s4_a    <= r_s3_a;
            r_s4_r    <= r_s3_r;
            r_s4_d    <= r_s3_d;
            r_s4_abs  <= r_s3_abs;
            r_s4_move <= r_s3_move;
            r_s4_s    <= r_s3_s;
            r_s4_axis <= r_s3_axis;
            r_s4_mode <= r_s3_mode;
        end
    end

    // Stage 5: curve sums and the cubic-mode rate.
    assign w_pd0 = r_s4_c0 * $signed({1'b0, r_s4_a});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s5_c1    <= 38'(r_s4_t1) + 38'(r_s4_lin);
            r_s5_inner <= 38'(r_s4_t2) + 38'(r_s4_lin);
            r_s5_deg0  <= 41'(rnd_shr(RW'(w_pd0), 14));
            r_s5_r     <= r_s4_r;
            r_s5_d     <= r_s4_d;
            r_s5_abs   <= r_s4_abs;
            r_s5_move  <= r_s4_move;
            r_s5_s     <= r_s4_s;
            r_s5_a     <= r_s4_a;
            r_s5_axis  <= r_s4_axis;
            r_s5_mode  <= r_s4_mode;
        end
    end

    // Stage 6: rc curve times rate, quintic expo times |x|, center term.
    always_comb begin
        w_pang = r_s5_c1 * $signed({1'b0, r_s5_r});
        w_prx  = $signed({1'b0, r_s5_abs}) * r_s5_inner;
        w_sa   = r_s5_s * $signed({1'b0, r_s5_a});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s6_angp  <= 33'(rnd_shr(RW'(w_pang), 26));
            r_s6_rexpo <= 38'(rnd_shr(RW'(w_prx), 15));
            r_s6_sa    <= w_sa;
            r_s6_deg0  <= r_s5_deg0;
            r_s6_d     <= r_s5_d;
            r_s6_move  <= r_s5_move;
            r_s6_axis  <= r_s5_axis;
            r_s6_mode  <= r_s5_mode;
        end
    end

    // Stage 7: scale the rc rate to deg/s and finish the quintic rate.
    always_comb begin
        w_pmv = $signed({1'b0, r_s6_move}) * r_s6_rexpo;
        w_c2  = (RW'(r_s6_sa) <<< 15) + RW'(w_pmv);
        w_ang = r_s6_angp * $signed({1'b0, RATE_SCALE});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.pay.axis <= r_s6_axis;
            r_res.pay.mode <= r_s6_mode;
            r_res.pay.deg0 <= r_s6_deg0;
            r_res.pay.deg2 <= 41'(rnd_shr(w_c2, 14));
            r_res.pay.ang  <= 41'(w_ang);
            r_res.den      <= r_s6_d;
        end
    end

    assign o_valid = r_v[6];
    assign o_res   = r_res;

endmodule

### rtl/srcv_div.sv
// ----------------------------------------------------------------------------
// Stick rate curve super-rate reciprocal
// Pipelined long division, one quotient bit per stage, for round(2^43 / d).
// ----------------------------------------------------------------------------
module srcv_div import srcv_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  t_curve_res           i_res,
    output logic                 o_valid,
    output t_div_pay             o_pay,
    output logic [DIV_STEPS-1:0] o_quo
);

    typedef struct packed {
        t_div_pay             pay;
        logic [27:0]          den;
        logic [27:0]          rem;
        logic [DIV_STEPS-1:0] quo;
    } t_div_st;

    t_div_st              r_st  [DIV_STEPS];
    t_div_st              w_in  [DIV_STEPS];
    t_div_st              w_out [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[DIV_STEPS-2:0], i_valid};
        end
    end

    // The numerator is 2^43 + d/2, so its low bits are d shifted down by one
    // and its top bits are 2^20 plus the top four bits of d.
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        localparam int QB = DIV_STEPS - 1 - k;
        logic [27:0] w_rem2;

        if (k == 0) begin : g_first
            always_comb begin
                w_in[k].pay = i_res.pay;
                w_in[k].den = i_res.den;
                w_in[k].rem = 28'({1'b1, 16'b0, i_res.den[27:24]});
                w_in[k].quo = '0;
            end
        end else begin : g_next
            assign w_in[k] = r_st[k-1];
        end

        always_comb begin
            w_rem2    = {w_in[k].rem[26:0], w_in[k].den[QB+1]};
            w_out[k]  = w_in[k];
            if (w_rem2 >= w_in[k].den) begin
                w_out[k].rem     = w_rem2 - w_in[k].den;
                w_out[k].quo[QB] = 1'b1;
            end else begin
                w_out[k].rem = w_rem2;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= w_out[k];
            end
        end
    end

    assign o_valid = r_v[DIV_STEPS-1];
    assign o_pay   = r_st[DIV_STEPS-1].pay;
    assign o_quo   = r_st[DIV_STEPS-1].quo;

endmodule

### rtl/srcv_final.sv
// ----------------------------------------------------------------------------
// Stick rate curve output stages
// Applies super rate, selects the curve, converts to rad/s and saturates.
// ----------------------------------------------------------------------------
module srcv_final import srcv_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_div_pay             i_pay,
    input  logic [DIV_STEPS-1:0] i_quo,
    output logic                 o_en,
    srcv_out_if.source           o_out
);

    logic [2:0]         r_v;
    logic signed [47:0] r_f1_deg1;
    logic signed [40:0] r_f1_deg0;
    logic signed [40:0] r_f1_deg2;
    logic [1:0]         r_f1_axis;
    logic [1:0]         r_f1_mode;
    logic signed [41:0] r_f2_deg;
    logic [1:0]         r_f2_axis;
    logic signed [35:0] r_f3_rad;
    logic [1:0]         r_f3_axis;
    logic               r_out_valid;
    logic [1:0]         r_out_axis;
    logic signed [31:0] r_out_rate;
    logic               r_out_sat;

    logic signed [64:0] w_pd1;
    logic signed [47:0] w_sel;
    logic signed [41:0] w_deg;
    logic signed [65:0] w_prad;

    // The whole back end advances whenever the output register can move.
    assign o_en = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else if (o_en) begin
            r_v         <= {r_v[1:0], i_valid};
            r_out_valid <= r_v[2];
        end
    end

    assign w_pd1 = i_pay.ang * $signed({1'b0, i_quo});

    always_comb begin
        unique case (r_f1_mode)
            MODE_CUBIC:   w_sel = 48'(r_f1_deg0);
            MODE_RC:      w_sel = r_f1_deg1;
            MODE_QUINTIC: w_sel = 48'(r_f1_deg2);
            default:      w_sel = '0;
        endcase
        if (w_sel > DEG_LIMIT) begin
            w_deg = 42'(DEG_LIMIT);
        end else if (w_sel < -DEG_LIMIT) begin
            w_deg = 42'(-DEG_LIMIT);
        end else begin
            w_deg = 42'(w_sel);
        end
    end

    assign w_prad = r_f2_deg * $signed({1'b0, DEG2RAD_Q28});

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_f1_deg1  <= 48'(rnd_shr(RW'(w_pd1), 16));
            r_f1_deg0  <= i_pay.deg0;
            r_f1_deg2  <= i_pay.deg2;
            r_f1_axis  <= i_pay.axis;
            r_f1_mode  <= i_pay.mode;
            r_f2_deg   <= w_deg;
            r_f2_axis  <= r_f1_axis;
            r_f3_rad   <= 36'(rnd_shr(RW'(w_prad), 28));
            r_f3_axis  <= r_f2_axis;
            r_out_axis <= r_f3_axis;
            if (r_f3_rad > RAD_MAX) begin
                r_out_rate <= 32'(RAD_MAX);
                r_out_sat  <= 1'b1;
            end else if (r_f3_rad < RAD_MIN) begin
                r_out_rate <= 32'(RAD_MIN);
                r_out_sat  <= 1'b1;
            end else begin
                r_out_rate <= 32'(r_f3_rad);
                r_out_sat  <= 1'b0;
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.axis_out  = r_out_axis;
    assign o_out.rate_rad  = r_out_rate;
    assign o_out.saturated = r_out_sat;

endmodule

### rtl/stick_rate_curve_unit.sv
// ----------------------------------------------------------------------------
// Stick rate curve unit
// Throughput: one item per cycle; every multiply and the 23-stage reciprocal
// pipeline advance together whenever the output register can move.
// A four-item queue behind the front end keeps accepting during output
// stalls until it is full.
// Reset clears all valid bits and queue pointers and zeroes the configuration
// registers; the datapath registers are not reset.
// ----------------------------------------------------------------------------
module stick_rate_curve_unit import srcv_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srcv_in_if.sink    i_in,
    srcv_cfg_if.sink   i_cfg,
    srcv_out_if.source o_out
);

    logic                 w_full;
    logic                 w_empty;
    logic                 w_push;
    logic                 w_pop;
    logic                 w_en;
    t_job                 w_job;
    t_job                 w_head;
    logic                 w_curve_valid;
    t_curve_res           w_curve_res;
    logic                 w_div_valid;
    t_div_pay             w_div_pay;
    logic [DIV_STEPS-1:0] w_div_quo;

    assign w_pop = w_en && !w_empty;

    srcv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_job)
    );

    srcv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    srcv_curve u_curve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (!w_empty),
        .i_job   (w_head),
        .o_valid (w_curve_valid),
        .o_res   (w_curve_res)
    );

    srcv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_curve_valid),
        .i_res   (w_curve_res),
        .o_valid (w_div_valid),
        .o_pay   (w_div_pay),
        .o_quo   (w_div_quo)
    );

    srcv_final u_final (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_valid),
        .i_pay   (w_div_pay),
        .i_quo   (w_div_quo),
        .o_en    (w_en),
        .o_out   (o_out)
    );

endmodule

### tb/tb_stick_rate_curve_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stick rate curve unit testbench
// Drives axis samples through every curve mode and expo selection, predicts
// each rate in fixed point and compares the results in arrival order.
// ----------------------------------------------------------------------------
module tb_stick_rate_curve_unit import srcv_pkg::*; ();

    localparam int  N_RANDOM    = 1600;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  DRAIN_WAIT  = 60;
    localparam int  HOLD_CYCLES = 300;

    typedef struct {
        logic [1:0]         axis;
        logic signed [15:0] stick;
        logic               level;
        logic               race;
        logic               horizon;
        logic               has_exp;
        logic signed [31:0] exp_rate;
        logic               exp_sat;
    } t_row;

    typedef struct {
        logic [1:0]         axis;
        logic signed [31:0] rate;
        logic               sat;
    } t_rate;

    logic i_clk;
    logic i_rst_n;

    srcv_in_if  in_ch ();
    srcv_out_if out_ch ();
    srcv_cfg_if cfg_ch ();

    stick_rate_curve_unit i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .i_cfg  (cfg_ch.sink),
        .o_out  (out_ch.source)
    );

    // Local copy of the registers.
    logic [1:0]  mode_q;
    logic [47:0] rate_a_q, rate_b_q, acro_q, angle_q;

    t_rate  rates_due[$];
    int     fail_cnt;
    int     cycle_cnt;
    int     result_cnt;
    int     sat_cnt;
    bit     calm;      // no idling on either side
    bit     hold_req;  // ask the receiver for a long hold-off
    bit     hold_done;

    initial i_clk = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic longint rshift_round(longint v, int n);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 <<< (n - 1))) >>> n;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint axis_word(logic [47:0] pack, logic [1:0] axis);
        logic [63:0] w;
        w = {16'h0, pack};
        return longint'((w >> (16 * axis)) & 64'hFFFF);
    endfunction

    function automatic t_rate stick_to_rate(logic [1:0] axis, logic signed [15:0] stick,
                                            logic level, logic race, logic horizon);
        t_rate  r;
        bit     use_angle;
        longint s, abs_s, e, a_w, b_w, lin, x2, x3, x4, xq, x5, curve, deg, rad;
        longint rc, ang, d, f, inner, rexpo, move;
        s     = longint'(stick);
        abs_s = s < 0 ? -s : s;
        a_w   = axis_word(rate_a_q, axis);
        b_w   = axis_word(rate_b_q, axis);
        deg   = 0;
        if (!level) use_angle = 0;
        else if (race && !horizon) use_angle = (axis != AXIS_PITCH);
        else if (horizon) use_angle = (axis == AXIS_YAW);
        else use_angle = 1;
        e   = axis_word(use_angle ? angle_q : acro_q, axis);
        lin = s * (4096 - e) * 8;
        x2  = s * s;
        x3  = rshift_round(x2 * s, 15);
        case (mode_q)
            MODE_CUBIC: begin
                curve = rshift_round(x3 * e, 12) + lin;
                deg   = rshift_round(curve * a_w, 14);
            end
            MODE_RC: begin
                x4    = rshift_round(x2 * x2, 30);
                xq    = rshift_round(x4 * s, 15);
                curve = rshift_round(xq * e, 12) + lin;
                rc    = a_w;
                if (rc > 8192) rc += rshift_round((rc - 8192) * 59556, 12);
                ang   = rshift_round(curve * rc, 26) * 200;
                d     = clip(134217728 - abs_s * b_w, 1342177, 134217728);
                f     = ((64'sd1 <<< 43) + d / 2) / d;
                deg   = rshift_round(ang * f, 16);
            end
            MODE_QUINTIC: begin
                x5    = rshift_round(x3 * x2, 30);
                inner = rshift_round(x5 * e, 12) + lin;
                rexpo = rshift_round(abs_s * inner, 15);
                move  = b_w - a_w;
                if (move < 0) move = 0;
                curve = s * a_w * 32768 + move * rexpo;
                deg   = rshift_round(curve, 14);
            end
            default: deg = 0;
        endcase
        deg   = clip(deg, -(64'sd1 <<< 40), 64'sd1 <<< 40);
        rad   = rshift_round(deg * 4685083, 28);
        r.sat = (rad > 64'sd2147483647) || (rad < -64'sd2147483648);
        rad   = clip(rad, -64'sd2147483648, 64'sd2147483647);
        r.axis = axis;
        r.rate = rad[31:0];
        return r;
    endfunction

    // Leaves valid high; the caller drops it after the last write.
    task automatic write_reg(logic [2:0] idx, logic [47:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_RATE_MODE:  mode_q   = data[1:0];
            REG_RATE_A:     rate_a_q = data;
            REG_RATE_B:     rate_b_q = data;
            REG_ACRO_EXPO:  acro_q   = data;
            REG_ANGLE_EXPO: angle_q  = data;
            default: ;
        endcase
    endtask

    task automatic load_setup(logic [1:0] mode, logic [47:0] a, logic [47:0] b,
                              logic [47:0] acro, logic [47:0] angle);
        write_reg(REG_RATE_MODE, {46'h0, mode});
        write_reg(REG_RATE_A, a);
        write_reg(REG_RATE_B, b);
        write_reg(REG_ACRO_EXPO, acro);
        write_reg(REG_ANGLE_EXPO, angle);
        cfg_ch.valid <= 1'b0;
    endtask

    // Offers one item, idling at random beforehand; valid stays high after it is taken.
    task automatic send_sample(t_row row);
        t_rate r;
        while (!calm && $urandom_range(99) < 33) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.axis_index <= row.axis;
        in_ch.stick      <= row.stick;
        in_ch.level_on   <= row.level;
        in_ch.race_on    <= row.race;
        in_ch.horizon_on <= row.horizon;
        do @(posedge i_clk); while (!in_ch.ready);
        r = stick_to_rate(row.axis, row.stick, row.level, row.race, row.horizon);
        if (row.has_exp) begin
            if (r.rate !== row.exp_rate || r.sat !== row.exp_sat)
                $error("directed row disagrees with predictor: rate %0d sat %0b",
                       r.rate, r.sat);
            r.rate = row.exp_rate;
            r.sat  = row.exp_sat;
        end
        rates_due.push_back(r);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (rates_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic t_row mk(logic [1:0] axis, int stick, bit lv, bit rc, bit hz,
                                bit has = 0, int er = 0, bit es = 0);
        t_row r;
        r.axis = axis; r.stick = stick[15:0]; r.level = lv; r.race = rc;
        r.horizon = hz; r.has_exp = has; r.exp_rate = er; r.exp_sat = es;
        return r;
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 33);
        end
    end

    initial begin
        hold_done = 0;
        wait (hold_req);
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_done = 1;
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_rate exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            result_cnt <= result_cnt + 1;
            if (rates_due.size() == 0) begin
                $error("result with no item outstanding");
                fail_cnt <= fail_cnt + 1;
            end else begin
                exp_r = rates_due.pop_front();
                if (exp_r.sat) sat_cnt <= sat_cnt + 1;
                if (out_ch.axis_out !== exp_r.axis) begin
                    $error("axis_out: expected %0d, got %0d", exp_r.axis, out_ch.axis_out);
                    fail_cnt <= fail_cnt + 1;
                end
                if (out_ch.rate_rad !== exp_r.rate) begin
                    $error("rate_rad: expected %0d, got %0d", exp_r.rate, out_ch.rate_rad);
                    fail_cnt <= fail_cnt + 1;
                end
                if (out_ch.saturated !== exp_r.sat) begin
                    $error("saturated: expected %0b, got %0b", exp_r.sat, out_ch.saturated);
                    fail_cnt <= fail_cnt + 1;
                end
            end
        end
    end

    function automatic logic [47:0] rand48();
        return {16'($urandom()), $urandom()};
    endfunction

    // Mostly realistic words, with occasional full-range values.
    function automatic logic [15:0] pick_word(int lo, int hi);
        return ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(hi, lo));
    endfunction

    function automatic logic [47:0] pick_pack(int lo, int hi);
        return {pick_word(lo, hi), pick_word(lo, hi), pick_word(lo, hi)};
    endfunction

    t_row directed[$];

    initial begin
        t_row  row;
        int    s;
        logic [1:0] m;
        fail_cnt = 0; cycle_cnt = 0; result_cnt = 0; sat_cnt = 0;
        calm = 0; hold_req = 0;
        mode_q = '0; rate_a_q = '0; rate_b_q = '0; acro_q = '0; angle_q = '0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0; in_ch.axis_index = '0; in_ch.stick = '0;
        in_ch.level_on = 1'b0; in_ch.race_on = 1'b0; in_ch.horizon_on = 1'b0;
        cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // After reset every rate is zero.
        directed.push_back(mk(AXIS_ROLL, 32767, 0, 0, 0, 1, 0, 0));
        directed.push_back(mk(AXIS_YAW, -32768, 1, 1, 1, 1, 0, 0));
        foreach (directed[i]) send_sample(directed[i]);
        wait_idle();

        // Extreme rates and expos in each mode, all switch combinations,
        // the unused axis code and the unused mode code.
        for (int md = 0; md < 4; md++) begin
            load_setup(md[1:0], 48'hFFFF_FFFF_FFFF, 48'hFFFF_0800_1000,
                       48'h1000_0800_0000, 48'hFFFF_0000_1000);
            directed.delete();
            directed.push_back(mk(2'd3, 32767, 1, 0, 0, 1, 0, 0));
            for (int k = 0; k < 8; k++) begin
                s = (k % 4 == 0) ? 32767 : (k % 4 == 1) ? -32768 :
                    (k % 4 == 2) ? 1 : 0;
                directed.push_back(mk(2'(k % 3), s, k[0], k[1], k[2]));
            end
            if (md == 3) directed.push_back(mk(AXIS_PITCH, 32767, 0, 0, 0, 1, 0, 0));
            foreach (directed[i]) send_sample(directed[i]);
            wait_idle();
        end

        // Random phases: new register values, then a burst of samples.
        for (int ph = 0; ph < 16; ph++) begin
            m = 2'(ph % 3);
            if (ph == 15) m = 2'd3;
            case (m)
                MODE_CUBIC:  load_setup(m, pick_pack(0, 2000), rand48(),
                                        pick_pack(0, 4096), pick_pack(0, 4096));
                MODE_RC:     load_setup(m, pick_pack(0, 16384), pick_pack(0, 4096),
                                        pick_pack(0, 4096), pick_pack(0, 4096));
                default:     load_setup(m, pick_pack(0, 400), pick_pack(0, 2000),
                                        pick_pack(0, 4096), pick_pack(0, 4096));
            endcase
            calm = (ph == 4);
            if (ph == 7) hold_req = 1;
            for (int n = 0; n < N_RANDOM / 16; n++) begin
                case ($urandom_range(3))
                    0: s = $urandom_range(65535) - 32768;
                    1: s = $urandom_range(2000) - 1000;
                    2: s = ($urandom_range(1)) ? 32767 - $urandom_range(50)
                                               : -32768 + $urandom_range(50);
                    default: s = $urandom_range(32767) - 16384;
                endcase
                row = mk(($urandom_range(15) == 0) ? 2'd3 : 2'($urandom_range(2)), s,
                         $urandom_range(1), $urandom_range(1), $urandom_range(1));
                send_sample(row);
            end
            calm = 0;
            wait_idle();
        end

        $display("Covered all curve modes, expo selections and %0d results (%0d saturated),",
                 result_cnt, sat_cnt);
        $display("with random stalls on both sides and one long output hold-off.");
        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
